// File: rtl/rkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_pkg: shared types and constants of the repeated k-mer detector
// Base character width, result code width, sighting counter encoding and
// the ASCII-to-2-bit nucleotide map.
// ----------------------------------------------------------------------------
package rkd_pkg;

	localparam int BASE_W = 8;
	localparam int CODE_OUT_W = 20;
	localparam int SEEN_W = 4;
	localparam int CNT_W = 2;

	typedef logic [BASE_W-1:0]     base_char_t;
	typedef logic [CODE_OUT_W-1:0] repeat_code_t;
	typedef logic [1:0]            nuc_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// ASCII nucleotide letters
	localparam base_char_t CHAR_A = 8'h41;
	localparam base_char_t CHAR_T = 8'h54;
	localparam base_char_t CHAR_C = 8'h43;
	localparam base_char_t CHAR_G = 8'h47;

	// 2-bit nucleotide codes
	localparam nuc_t NUC_A = 2'd0;
	localparam nuc_t NUC_T = 2'd1;
	localparam nuc_t NUC_C = 2'd2;
	localparam nuc_t NUC_G = 2'd3;

	// sighting counter saturates at two
	localparam cnt_t CNT_SAT = 2'd2;

	// unknown characters map to the code of A
	function automatic nuc_t encode_base(input base_char_t ch);
		nuc_t nuc;
		case (ch)
			CHAR_A:  nuc = NUC_A;
			CHAR_T:  nuc = NUC_T;
			CHAR_C:  nuc = NUC_C;
			CHAR_G:  nuc = NUC_G;
			default: nuc = NUC_A;
		endcase
		return nuc;
	endfunction

endpackage

// File: rtl/rkd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkd_if: stream channels of the repeated k-mer detector
// rkd_base_if carries one ASCII base per transaction; rkd_code_if carries
// one repeated window code per transaction. Valid/ready handshake.
// ----------------------------------------------------------------------------
interface rkd_base_if;
	logic                 valid;
	logic                 ready;
	rkd_pkg::base_char_t  base_char;

	modport source (output valid, output base_char, input ready);
	modport sink (input valid, input base_char, output ready);
endinterface

interface rkd_code_if;
	logic                  valid;
	logic                  ready;
	rkd_pkg::repeat_code_t repeat_code;

	modport source (output valid, output repeat_code, input ready);
	modport sink (input valid, input repeat_code, output ready);
endinterface

// File: rtl/repeated_kmer_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeated_kmer_detector: reports each window code at its second sighting
// Rolling window of WINDOW_BASES 2-bit bases; a sighting counter per window
// code lives in a single synchronous memory updated by read-modify-write.
//
//   channel   direction  payload            per transaction
//   bases     in         base_char [7:0]    one ASCII nucleotide
//   repeats   out        repeat_code [19:0] one window code seen twice
//
// One base per cycle sustained while bases.ready is high; a result goes via
// the stage 1 register to the output register, or to the skid when stalled.
// The count table has one read and one write port; back-to-back hits on the
// same code are served from the write-back register. After reset a clearing
// pass zeroes all 2**(2*WINDOW_BASES) entries (1,048,576 at the default),
// one entry a cycle, with bases.ready low. Output register and one-entry skid
// absorb stalls; bases.ready drops if skid is taken or stage 1 meets a stall.
// ----------------------------------------------------------------------------
module repeated_kmer_detector #(
	parameter int WINDOW_BASES = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	rkd_base_if.sink   bases,
	rkd_code_if.source repeats
);
	import rkd_pkg::*;

	localparam int CODE_BITS = 2 * WINDOW_BASES;
	localparam int TABLE_SIZE = 1 << CODE_BITS;
	localparam logic [SEEN_W-1:0] WinCount = SEEN_W'(WINDOW_BASES);

	typedef logic [CODE_BITS-1:0] code_t;

	// count table
	cnt_t count_mem [TABLE_SIZE];

	// control and state
	logic               clearing_q;
	code_t              clr_addr_q;
	code_t              window_q;
	logic [SEEN_W-1:0]  seen_q;
	logic               s1_valid_q;
	code_t              addr_s1;
	cnt_t               rd_data_s1;
	logic               wr_valid_q;
	code_t              wr_addr_q;
	cnt_t               wr_data_q;
	logic               out_valid_q;
	repeat_code_t       out_code_q;
	logic               skid_valid_q;
	repeat_code_t       skid_code_q;

	// combinational
	logic               accept;
	logic               pop;
	code_t              win_next;
	logic [SEEN_W-1:0]  seen_next;
	logic               win_full;
	cnt_t               cnt_s1;
	logic               item_we;
	logic               push;
	repeat_code_t       push_code;
	logic               mem_we;
	code_t              mem_waddr;
	cnt_t               mem_wdata;

	// input stage: shift the new base into the window
	always_comb begin
		win_next  = CODE_BITS'({window_q, encode_base(bases.base_char)});
		seen_next = (seen_q < WinCount) ? seen_q + 1'b1 : seen_q;
		win_full  = (seen_next == WinCount);
	end

	assign pop = out_valid_q && repeats.ready;
	assign bases.ready = !clearing_q && !skid_valid_q &&
		!(s1_valid_q && out_valid_q && !repeats.ready);
	assign accept = bases.valid && bases.ready;

	// stage 1: forward the previous write-back, count and decide
	always_comb begin
		cnt_s1    = (wr_valid_q && wr_addr_q == addr_s1) ? wr_data_q : rd_data_s1;
		item_we   = s1_valid_q && (cnt_s1 < CNT_SAT);
		push      = item_we && (cnt_s1 + 1'b1 == CNT_SAT);
		push_code = CODE_OUT_W'(addr_s1);
	end

	// write port shared by the clearing pass and the counter update
	always_comb begin
		mem_we    = clearing_q || item_we;
		mem_waddr = clearing_q ? clr_addr_q : addr_s1;
		mem_wdata = clearing_q ? '0 : cnt_t'(cnt_s1 + 1'b1);
	end

	// count table ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			count_mem[mem_waddr] <= mem_wdata;
		end
		if (accept && win_full) begin
			rd_data_s1 <= count_mem[win_next];
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// window, fill count and stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			seen_q     <= '0;
			s1_valid_q <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept && win_full;
			wr_valid_q <= item_we;
			if (accept) begin
				window_q <= win_next;
				seen_q   <= seen_next;
			end
		end
	end

	// payload of stage 1 and write-back register
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= win_next;
		end
		wr_addr_q <= addr_s1;
		wr_data_q <= cnt_t'(cnt_s1 + 1'b1);
	end

	// output register with one-entry skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_code_q <= skid_code_q;
			end else if (push) begin
				out_code_q <= push_code;
			end
		end else if (push) begin
			skid_code_q <= push_code;
		end
	end

	assign repeats.valid       = out_valid_q;
	assign repeats.repeat_code = out_code_q;

	// checks
	a_no_skid_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && skid_valid_q))
		else $error("result arrived while skid entry occupied");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while output register is empty");

	a_s1_window_full: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> seen_q == WinCount)
		else $error("table access before the window filled");

	a_clear_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> clr_addr_q == '0)
		else $error("clearing pass ended before covering the table");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s1_valid_q && !out_valid_q)
		else $error("activity during clearing pass");

endmodule
